@@ src/psp_pkg.sv @@
// shared constants, tables and types for the pitched sample player
`timescale 1ns / 1ps
package psp_pkg;

  // default sizes handed to the top level
  localparam int MAX_FRAMES_DEF = 65536;
  localparam int CHANNELS_DEF   = 2;
  localparam int FRAC_BITS_DEF  = 16;

  // request and register field widths
  localparam int CMD_W          = 2;
  localparam int CHAN_IN_W      = 3;
  localparam int FRAME_IN_W     = 16;
  localparam int SAMPLE_W       = 16;
  localparam int RATE_W         = 19;
  localparam int INTERVAL_W     = 6;
  localparam int FRAMES_REG_W   = 17;
  localparam int CHANNELS_REG_W = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 19;

  // register reset values
  localparam logic signed [RATE_W-1:0]     RATE_RESET     = 19'sd65536;
  localparam logic signed [INTERVAL_W-1:0] INTERVAL_RESET = 6'sd0;
  localparam logic [FRAMES_REG_W-1:0]      FRAMES_RESET   = 17'd65536;
  localparam logic [CHANNELS_REG_W-1:0]    CHANNELS_RESET = 4'd2;

  // request codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEEK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PLAYBACK_RATE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEMITONE_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS_IN_USE   = 2'd3;

  localparam int MIN_FRAMES = 16;

  // shared multiplier size
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;

  // semitone ratio table, Q3.16, interval -24..24
  localparam int INTERVAL_LIMIT = 24;
  localparam int RATIO_ENTRIES  = 2 * INTERVAL_LIMIT + 1;
  localparam int RATIO_W        = 19;
  localparam int RATIO_FRAC     = 16;
  localparam logic [RATIO_W-1:0] RATIO_ROM [RATIO_ENTRIES] = '{
    19'd16384,  19'd17358,  19'd18390,  19'd19484,  19'd20643,  19'd21870,
    19'd23170,  19'd24548,  19'd26008,  19'd27554,  19'd29193,  19'd30929,
    19'd32768,  19'd34716,  19'd36781,  19'd38968,  19'd41285,  19'd43740,
    19'd46341,  19'd49097,  19'd52016,  19'd55109,  19'd58386,  19'd61858,
    19'd65536,  19'd69433,  19'd73562,  19'd77936,  19'd82570,  19'd87480,
    19'd92682,  19'd98193,  19'd104032, 19'd110218, 19'd116772, 19'd123715,
    19'd131072, 19'd138866, 19'd147123, 19'd155872, 19'd165140, 19'd174960,
    19'd185364, 19'd196386, 19'd208064, 19'd220436, 19'd233544, 19'd247431,
    19'd262144
  };

  // crossfade table: (1 - cos(pi*k/N))/2 in Q0.16
  localparam int COS_TABLE_ENTRIES = 256;
  localparam int COS_BITS          = $clog2(COS_TABLE_ENTRIES);
  localparam int MU_W              = 17;
  localparam int MU_FRAC           = 16;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam int TAYLOR_TERMS = 7;
  localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182
  };

  typedef logic [MU_W-1:0] fade_rom_t [COS_TABLE_ENTRIES];

  // cos(pi*k/N) in Q30 on the first quarter wave, Taylor series
  function automatic logic [63:0] quarter_cos(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] acc;
    x   = (PI_Q30 * k) / COS_TABLE_ENTRIES;
    x2  = (x * x) >> 30;
    t   = ONE_Q30;
    acc = $signed(ONE_Q30);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      t = ((t * x2) >> 30) / TAYLOR_DIV[n];
      if ((n & 1) == 0) begin
        acc = acc - $signed(t);
      end else begin
        acc = acc + $signed(t);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    if (acc > $signed(ONE_Q30)) begin
      acc = $signed(ONE_Q30);
    end
    return $unsigned(acc);
  endfunction

  // one crossfade weight, rounded to Q16
  function automatic logic [MU_W-1:0] fade_value(input logic [63:0] k);
    logic [63:0] m30;
    if (2 * k <= COS_TABLE_ENTRIES) begin
      m30 = ONE_Q30 - quarter_cos(k);
    end else begin
      m30 = ONE_Q30 + quarter_cos(64'(COS_TABLE_ENTRIES) - k);
    end
    return MU_W'((m30 + 64'd16384) >> 15);
  endfunction

  function automatic fade_rom_t build_fade_rom();
    fade_rom_t rom;
    for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
      rom[k] = fade_value(64'(k));
    end
    return rom;
  endfunction

  localparam fade_rom_t FADE_ROM = build_fade_rom();

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SUM,
    ST_WRAP,
    ST_MOD,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_DIFF,
    ST_EMIT
  } psp_state_t;

endpackage

@@ src/psp_ram.sv @@
// generic single-port sample memory with registered read
`timescale 1ns / 1ps
module psp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-before-write port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/psp_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module psp_mul
  import psp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ src/pitched_sample_player.sv @@
// pitched sample player: variable-rate playback with cosine interpolation
// write and seek requests do not leave the idle state; the block is ready again next cycle
// a tick runs round, sum, wrap and a one-bit-per-cycle position modulo, then four steps per
// channel (fetch A, fetch B, diff, emit); output stalls hold the emit step
// reset: registers to defaults, position zero; sample memory is not cleared
`timescale 1ns / 1ps
module pitched_sample_player
  import psp_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [CMD_W-1:0]              cmd,
  input  logic [CHAN_IN_W-1:0]          channel_index,
  input  logic [FRAME_IN_W-1:0]         frame_index,
  input  logic signed [SAMPLE_W-1:0]    sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHAN_IN_W-1:0]          channel_out,
  output logic signed [SAMPLE_W-1:0]    sample_out,
  output logic                          last
);

  localparam int FRAME_W   = $clog2(MAX_FRAMES);
  localparam int EFF_W     = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W     = (EFF_W > FRAMES_REG_W) ? EFF_W : FRAMES_REG_W;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NCH_W     = $clog2(CHANNELS + 1);
  localparam int DEPTH     = CHANNELS << FRAME_W;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = FRAME_W + FRAC_BITS;
  localparam int SUM_W     = POS_W + 2;
  localparam int STEP_W    = FRAC_BITS + 6;
  localparam int LEN_W     = EFF_W + FRAC_BITS;
  localparam int MOD_STEPS = FRAME_W - 3;
  localparam int DIV_W     = EFF_W + FRAC_BITS + MOD_STEPS - 1;
  localparam int MODC_W    = $clog2(MOD_STEPS + 1);
  localparam int RND_SH    = 2 * RATIO_FRAC - FRAC_BITS;
  localparam int IDX_W     = $clog2(RATIO_ENTRIES);

  // configuration registers
  logic signed [RATE_W-1:0]     playback_rate;
  logic signed [INTERVAL_W-1:0] semitone_interval;
  logic [FRAMES_REG_W-1:0]      frames_in_use;
  logic [CHANNELS_REG_W-1:0]    channels_in_use;

  // sequencer and datapath registers
  psp_state_t                state, state_next;
  logic [POS_W-1:0]          pos;
  logic signed [STEP_W-1:0]  step;
  logic signed [SUM_W-1:0]   sum;
  logic [DIV_W-1:0]          rem;
  logic [DIV_W-1:0]          div;
  logic [MODC_W-1:0]         mod_cnt;
  logic [CH_W-1:0]           chan;
  logic [FRAME_W-1:0]        nxt;
  logic [MU_W-1:0]           mu;
  logic signed [SAMPLE_W-1:0] v1;

  // shared unit and memory wiring
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic signed [SAMPLE_W-1:0] ram_rdata;

  logic                       in_accept;
  logic                       out_load;

  // effective frame count, clamped to [MIN_FRAMES, MAX_FRAMES]
  logic [CMP_W-1:0] fiu_wide;
  logic [EFF_W-1:0] eff_f;
  logic [LEN_W-1:0] len;

  always_comb begin
    fiu_wide = CMP_W'(frames_in_use);
    if (fiu_wide < CMP_W'(MIN_FRAMES)) begin
      fiu_wide = CMP_W'(MIN_FRAMES);
    end
    if (fiu_wide > CMP_W'(MAX_FRAMES)) begin
      fiu_wide = CMP_W'(MAX_FRAMES);
    end
    eff_f = fiu_wide[EFF_W-1:0];
    len   = {eff_f, {FRAC_BITS{1'b0}}};
  end

  // request frame clamped below the frame count
  logic [CMP_W-1:0]   frame_wide;
  logic [FRAME_W-1:0] frame_cl;

  always_comb begin
    frame_wide = CMP_W'(frame_index);
    if (frame_wide >= CMP_W'(eff_f)) begin
      frame_wide = CMP_W'(eff_f) - CMP_W'(1);
    end
    frame_cl = frame_wide[FRAME_W-1:0];
  end

  // channel count clamped to [1, CHANNELS]
  logic [NCH_W-1:0] nch;

  always_comb begin
    if (channels_in_use == '0) begin
      nch = NCH_W'(1);
    end else if (channels_in_use > CHANNELS_REG_W'(CHANNELS)) begin
      nch = NCH_W'(CHANNELS);
    end else begin
      nch = channels_in_use[NCH_W-1:0];
    end
  end

  // interval clamp and ratio lookup
  logic signed [INTERVAL_W-1:0] iv_cl;
  logic [IDX_W-1:0]             ratio_idx;
  logic [RATIO_W-1:0]           ratio;

  always_comb begin
    iv_cl = semitone_interval;
    if (iv_cl < -INTERVAL_W'(INTERVAL_LIMIT)) begin
      iv_cl = -INTERVAL_W'(INTERVAL_LIMIT);
    end
    if (iv_cl > INTERVAL_W'(INTERVAL_LIMIT)) begin
      iv_cl = INTERVAL_W'(INTERVAL_LIMIT);
    end
    ratio_idx = IDX_W'(iv_cl + INTERVAL_W'(INTERVAL_LIMIT));
    ratio     = RATIO_ROM[ratio_idx];
  end

  // step rounding, ties away from zero
  logic signed [PROD_W-1:0] rnd_bias, prod_rnd;

  always_comb begin
    if (prod[PROD_W-1]) begin
      rnd_bias = $signed(PROD_W'((64'd1 << (RND_SH - 1)) - 64'd1));
    end else begin
      rnd_bias = $signed(PROD_W'(64'd1 << (RND_SH - 1)));
    end
    prod_rnd = (prod + rnd_bias) >>> RND_SH;
  end

  // single wrap of the new position
  logic signed [SUM_W-1:0] len_s, wrapped;

  always_comb begin
    len_s = $signed(SUM_W'(len));
    if (sum >= len_s) begin
      wrapped = sum - len_s;
    end else if (sum[SUM_W-1]) begin
      wrapped = sum + len_s;
    end else begin
      wrapped = sum;
    end
  end

  // one restoring modulo step
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    if (rem >= div) begin
      rem_next = rem - div;
    end else begin
      rem_next = rem;
    end
  end

  // neighbour frame and crossfade weight
  logic [FRAME_W-1:0] idx;
  logic [EFF_W-1:0]   idx_inc;
  logic [FRAME_W-1:0] nxt_next;
  logic [COS_BITS-1:0] fade_idx;

  always_comb begin
    idx      = pos[POS_W-1:FRAC_BITS];
    idx_inc  = EFF_W'(idx) + EFF_W'(1);
    nxt_next = (idx_inc >= eff_f) ? '0 : idx_inc[FRAME_W-1:0];
    fade_idx = pos[FRAC_BITS-1 -: COS_BITS];
  end

  // interpolation: v1 * 2^16 + (v2 - v1) * mu, rounded
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   acc, res;
  logic [NCH_W-1:0]           chan_inc;
  logic                       chan_last;

  always_comb begin
    diff      = {ram_rdata[SAMPLE_W-1], ram_rdata} - {v1[SAMPLE_W-1], v1};
    acc       = (PROD_W'(v1) <<< MU_FRAC) + prod
                + $signed(PROD_W'(64'd1 << (MU_FRAC - 1)));
    res       = acc >>> MU_FRAC;
    chan_inc  = NCH_W'(chan) + NCH_W'(1);
    chan_last = (chan_inc == nch);
  end

  // operand select for the shared multiplier; held while the sample waits
  always_comb begin
    if ((state == ST_DIFF) || (state == ST_EMIT)) begin
      mul_a = MUL_W'(diff);
      mul_b = $signed(MUL_W'(mu));
    end else begin
      mul_a = MUL_W'(playback_rate);
      mul_b = $signed(MUL_W'(ratio));
    end
  end

  psp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // memory port: request writes when idle, fetches during a tick
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ram_we    = in_accept && (cmd == CMD_WRITE)
                     && (channel_index < CHAN_IN_W'(CHANNELS));

  always_comb begin
    unique case (state) inside
      ST_FETCH_A:                    ram_addr = ADDR_W'({chan, idx});
      ST_FETCH_B, ST_DIFF, ST_EMIT:  ram_addr = ADDR_W'({chan, nxt});
      default:    ram_addr = ADDR_W'({channel_index[CH_W-1:0], frame_cl});
    endcase
  end

  psp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_in),
    .rdata (ram_rdata)
  );

  assign out_load = (state == ST_EMIT) && (!out_valid || !out_stall);

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (cmd == CMD_TICK)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND:   state_next = ST_SUM;
      ST_SUM:     state_next = ST_WRAP;
      ST_WRAP:    state_next = ST_MOD;
      ST_MOD: begin
        if (mod_cnt == '0) begin
          state_next = ST_FETCH_A;
        end
      end
      ST_FETCH_A: state_next = ST_FETCH_B;
      ST_FETCH_B: state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_next = chan_last ? ST_IDLE : ST_FETCH_A;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      playback_rate     <= RATE_RESET;
      semitone_interval <= INTERVAL_RESET;
      frames_in_use     <= FRAMES_RESET;
      channels_in_use   <= CHANNELS_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_PLAYBACK_RATE:     playback_rate     <= $signed(cfg_data[RATE_W-1:0]);
        REG_SEMITONE_INTERVAL: semitone_interval <= $signed(cfg_data[INTERVAL_W-1:0]);
        REG_FRAMES_IN_USE:     frames_in_use     <= cfg_data[FRAMES_REG_W-1:0];
        REG_CHANNELS_IN_USE:   channels_in_use   <= cfg_data[CHANNELS_REG_W-1:0];
      endcase
    end
  end

  // read position: seek, then updated by the tick sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_accept && (cmd == CMD_SEEK)) begin
      pos <= {frame_cl, {FRAC_BITS{1'b0}}};
    end else if ((state == ST_MOD) && (mod_cnt == '0)) begin
      pos <= rem_next[POS_W-1:0];
    end
  end

  // tick datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        chan <= '0;
      end
      ST_ROUND: begin
        step <= prod_rnd[STEP_W-1:0];
      end
      ST_SUM: begin
        sum <= $signed({2'b00, pos}) + SUM_W'(step);
      end
      ST_WRAP: begin
        rem     <= DIV_W'(wrapped[SUM_W-2:0]);
        div     <= DIV_W'(len) << (MOD_STEPS - 1);
        mod_cnt <= MODC_W'(MOD_STEPS - 1);
      end
      ST_MOD: begin
        rem     <= rem_next;
        div     <= div >> 1;
        mod_cnt <= mod_cnt - MODC_W'(1);
      end
      ST_FETCH_A: begin
        nxt <= nxt_next;
        mu  <= FADE_ROM[fade_idx];
      end
      ST_FETCH_B: begin
        v1 <= ram_rdata;
      end
      ST_EMIT: begin
        if (out_load) begin
          chan <= chan + CH_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_out <= CHAN_IN_W'(chan);
      sample_out  <= res[SAMPLE_W-1:0];
      last        <= chan_last;
    end
  end

endmodule
